// File: rtl/core/tbt_pkg.sv
`timescale 1ns / 1ps

package tbt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_IDENT = 4'b0010,
    MODE_INT   = 4'b0100,
    MODE_STR   = 4'b1000
  } mode_e;

  localparam int unsigned NUM_KW      = 10;
  localparam int unsigned MAX_LETTERS = 6;
  localparam int unsigned NUM_OPS     = 8;

  localparam logic [4:0] KIND_VAR  = 5'd10;
  localparam logic [4:0] KIND_INT  = 5'd11;
  localparam logic [4:0] KIND_OP0  = 5'd12;
  localparam logic [4:0] KIND_SCHR = 5'd20;
  localparam logic [4:0] KIND_SEND = 5'd21;
  localparam logic [4:0] KIND_ERR  = 5'd22;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [2:0] LETTERS_FULL = 3'd6;
  localparam logic [2:0] LETTERS_SAT  = 3'd7;

  // Keyword spellings, letters as 0..25, unused tail entries zero
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd6, 3'd3, 3'd3
  };
  localparam logic [4:0] KW_TEXT [NUM_KW][MAX_LETTERS] = '{
    '{5'd11, 5'd4,  5'd19, 5'd0,  5'd0,  5'd0 },  // LET
    '{5'd15, 5'd17, 5'd8,  5'd13, 5'd19, 5'd0 },  // PRINT
    '{5'd8,  5'd13, 5'd15, 5'd20, 5'd19, 5'd0 },  // INPUT
    '{5'd8,  5'd5,  5'd0,  5'd0,  5'd0,  5'd0 },  // IF
    '{5'd19, 5'd7,  5'd4,  5'd13, 5'd0,  5'd0 },  // THEN
    '{5'd6,  5'd14, 5'd19, 5'd14, 5'd0,  5'd0 },  // GOTO
    '{5'd6,  5'd14, 5'd18, 5'd20, 5'd1,  5'd0 },  // GOSUB
    '{5'd17, 5'd4,  5'd19, 5'd20, 5'd17, 5'd13},  // RETURN
    '{5'd17, 5'd4,  5'd12, 5'd0,  5'd0,  5'd0 },  // REM
    '{5'd17, 5'd20, 5'd13, 5'd0,  5'd0,  5'd0 }   // RUN
  };

  localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
    8'h3D, 8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3E
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_hit_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic kw_hit_t kw_lookup(input logic [4:0] letters [MAX_LETTERS],
                                        input logic [2:0] cnt);
    kw_hit_t r;
    logic    eq;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      eq = (cnt == KW_LEN[k]);
      for (int i = 0; i < MAX_LETTERS; i++) begin
        if ((3'(i) < KW_LEN[k]) && (letters[i] != KW_TEXT[k][i])) begin
          eq = 1'b0;
        end
      end
      if (eq && !r.hit) begin
        r.hit = 1'b1;
        r.idx = 4'(k);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/tbt_res_fifo.sv
`timescale 1ns / 1ps

module tbt_res_fifo import tbt_pkg::*; #(
  parameter int unsigned WIDTH = 70
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  logic [WIDTH-1:0] din0_i,
  input  logic [WIDTH-1:0] din1_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] dout_o
);

  localparam int unsigned DEPTH = 4;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [1:0]       wr_ptr_q, wr_ptr_d;
  logic [1:0]       rd_ptr_q, rd_ptr_d;
  logic [2:0]       count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != 3'd0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // room for two words regardless of the pop
  assign space_o = (count_q <= 3'd2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n_i;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_n_i} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= din0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= din1_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q <= 3'd2))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(DEPTH))
    else $error("result queue count out of range");

endmodule

// File: rtl/core/tbt_lexer.sv
`timescale 1ns / 1ps

module tbt_lexer import tbt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             ch_i,
  input  logic                   end_of_text_i,
  input  logic                   space_i,
  output logic [1:0]             push_n_o,
  output logic [4:0]             kind0_o,
  output logic [VALUE_WIDTH-1:0] val0_o,
  output logic [4:0]             kind1_o,
  output logic [VALUE_WIDTH-1:0] val1_o
);

  localparam int unsigned VW = VALUE_WIDTH;

  // input register
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       eot_q;
  logic       adv;

  // lexer state
  mode_e         mode_q, mode_d;
  logic [4:0]    letters_q [MAX_LETTERS];
  logic [4:0]    letters_d [MAX_LETTERS];
  logic [2:0]    count_q, count_d;
  logic [VW-1:0] acc_q, acc_d;
  logic          halted_q, halted_d;

  // start-of-token decode of the current byte
  logic          st_emit, st_halt, st_acc, st_let;
  logic [4:0]    st_kind;
  logic [7:0]    st_val;
  mode_e         st_mode;

  // identifier flush
  kw_hit_t       kw;
  logic [4:0]    fl_kind;
  logic [VW-1:0] fl_val;
  logic          fl_err;

  assign adv        = in_vld_q && space_i;
  assign in_ready_o = !in_vld_q || space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q  <= ch_i;
      eot_q <= end_of_text_i;
    end
  end

  always_comb begin
    st_emit = 1'b0;
    st_halt = 1'b0;
    st_acc  = 1'b0;
    st_let  = 1'b0;
    st_kind = KIND_ERR;
    st_val  = ch_q;
    st_mode = MODE_IDLE;
    if (is_space(ch_q)) begin
      st_mode = MODE_IDLE;
    end else if (is_digit(ch_q)) begin
      st_mode = MODE_INT;
      st_acc  = 1'b1;
    end else if (is_letter(ch_q)) begin
      st_mode = MODE_IDENT;
      st_let  = 1'b1;
    end else if (ch_q == CH_QUOTE) begin
      st_mode = MODE_STR;
    end else begin
      st_emit = 1'b1;
      st_halt = 1'b1;
      for (int i = 0; i < NUM_OPS; i++) begin
        if (ch_q == OP_CHARS[i]) begin
          st_halt = 1'b0;
          st_kind = KIND_OP0 + 5'(i);
          st_val  = 8'h00;
        end
      end
    end
  end

  always_comb begin
    kw      = kw_lookup(letters_q, count_q);
    fl_err  = 1'b0;
    fl_kind = {1'b0, kw.idx};
    fl_val  = '0;
    if (!kw.hit) begin
      if (count_q == 3'd1) begin
        fl_kind = KIND_VAR;
        fl_val  = VW'(letters_q[0]);
      end else begin
        fl_kind = KIND_ERR;
        fl_val  = VW'({3'b000, letters_q[0]} + CH_A);
        fl_err  = 1'b1;
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    letters_d = letters_q;
    count_d   = count_q;
    acc_d     = acc_q;
    halted_d  = halted_q;
    push_n_o  = 2'd0;
    kind0_o   = st_kind;
    val0_o    = VW'(st_val);
    kind1_o   = st_kind;
    val1_o    = VW'(st_val);

    if (adv && !halted_q) begin
      if (eot_q) begin
        mode_d = MODE_IDLE;
        case (mode_q)
          MODE_IDENT: begin
            push_n_o = 2'd1;
            kind0_o  = fl_kind;
            val0_o   = fl_val;
            halted_d = fl_err;
          end
          MODE_INT: begin
            push_n_o = 2'd1;
            kind0_o  = KIND_INT;
            val0_o   = acc_q;
          end
          MODE_STR: begin
            push_n_o = 2'd1;
            kind0_o  = KIND_ERR;
            val0_o   = VW'(CH_QMARK);
            halted_d = 1'b1;
          end
          default: ;
        endcase
      end else begin
        case (mode_q)
          MODE_IDENT: begin
            if (is_letter(ch_q)) begin
              if (count_q < LETTERS_FULL) begin
                letters_d[count_q] = 5'(ch_q - CH_A);
              end
              if (count_q != LETTERS_SAT) begin
                count_d = count_q + 3'd1;
              end
            end else begin
              push_n_o = 2'd1;
              kind0_o  = fl_kind;
              val0_o   = fl_val;
              mode_d   = MODE_IDLE;
              if (fl_err) begin
                halted_d = 1'b1;
              end else begin
                push_n_o = {st_emit, !st_emit};
                mode_d   = st_mode;
                halted_d = st_halt;
              end
            end
          end
          MODE_INT: begin
            if (is_digit(ch_q)) begin
              acc_d = (acc_q << 3) + (acc_q << 1) + VW'(ch_q[3:0]);
            end else begin
              push_n_o = {st_emit, !st_emit};
              kind0_o  = KIND_INT;
              val0_o   = acc_q;
              mode_d   = st_mode;
              halted_d = st_halt;
            end
          end
          MODE_STR: begin
            push_n_o = 2'd1;
            if (ch_q == CH_QUOTE) begin
              mode_d  = MODE_IDLE;
              kind0_o = KIND_SEND;
              val0_o  = '0;
            end else begin
              kind0_o = KIND_SCHR;
              val0_o  = VW'(ch_q);
            end
          end
          default: begin
            push_n_o = {1'b0, st_emit};
            mode_d   = st_mode;
            halted_d = st_halt;
          end
        endcase
        // a fresh token takes over the accumulator or the letter buffer
        if (!(mode_q == MODE_IDENT && fl_err) && mode_d != mode_q || mode_q == MODE_IDLE
            || (mode_q == MODE_IDENT && !is_letter(ch_q) && !fl_err)
            || (mode_q == MODE_INT && !is_digit(ch_q))) begin
          if (mode_q != MODE_STR) begin
            if (st_acc) begin
              acc_d = VW'(ch_q[3:0]);
            end
            if (st_let) begin
              letters_d[0] = 5'(ch_q - CH_A);
              count_d      = 3'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      letters_q <= '{default: '0};
      count_q   <= '0;
      acc_q     <= '0;
      halted_q  <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      letters_q <= letters_d;
      count_q   <= count_d;
      acc_q     <= acc_d;
      halted_q  <= halted_d;
    end
  end

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (push_n_o == 2'd0))
    else $error("result produced while halted");

  a_push_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o != 2'd0) |-> (adv && !halted_q))
    else $error("result produced without a word");

endmodule

// File: rtl/core/tiny_basic_tokenizer_unit.sv
`timescale 1ns / 1ps

// Tiny BASIC tokenizer. Takes one source byte (or an end-of-text mark) per
// word and returns tokens: ten keywords, single-letter variables, wrapping
// decimal integers of VALUE_WIDTH bits, eight operators, quoted strings one
// character per word followed by an end word, and one error word after which
// the unit stays silent until reset. last_o marks the final result of each
// input word. Each input word is held in the input register and decoded from
// there; the unit takes a word every cycle while the four-entry result queue
// has room for two results, so the sustained rate is one input word per cycle
// while the consumer keeps out_ready_i high, limited by the output side
// draining one result per cycle when a word yields two results (a token
// closed by an operator or by a bad character).
module tiny_basic_tokenizer_unit import tbt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             ch_i,
  input  logic                   end_of_text_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [4:0]             token_kind_o,
  output logic [VALUE_WIDTH-1:0] token_value_o,
  output logic                   last_o
);

  localparam int unsigned ENTRY_W = 5 + 1 + VALUE_WIDTH;

  logic [1:0]             push_n;
  logic                   space;
  logic [4:0]             kind0, kind1;
  logic [VALUE_WIDTH-1:0] val0, val1;
  logic [ENTRY_W-1:0]     din0, din1, dout;

  tbt_lexer #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lexer (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .ch_i,
    .end_of_text_i,
    .space_i  (space),
    .push_n_o (push_n),
    .kind0_o  (kind0),
    .val0_o   (val0),
    .kind1_o  (kind1),
    .val1_o   (val1)
  );

  // first of two results is never last; a lone result always is
  assign din0 = {kind0, (push_n == 2'd1), val0};
  assign din1 = {kind1, 1'b1, val1};

  tbt_res_fifo #(
    .WIDTH(ENTRY_W)
  ) u_res_fifo (
    .clk_i,
    .rst_ni,
    .push_n_i (push_n),
    .din0_i   (din0),
    .din1_i   (din1),
    .space_o  (space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .dout_o   (dout)
  );

  assign token_kind_o  = dout[ENTRY_W-1 -: 5];
  assign last_o        = dout[VALUE_WIDTH];
  assign token_value_o = dout[VALUE_WIDTH-1:0];

endmodule
